[sv/wsg_pkg.sv]
`default_nettype none
package wsg_pkg;
  localparam int unsigned NCH = 5;
  localparam int unsigned WLEN = 32;
  localparam int unsigned WAVE_DEPTH = NCH * WLEN;
  localparam int unsigned WAVE_AW = $clog2(WAVE_DEPTH);
  localparam longint unsigned HALF_CLOCK = 1789772;
  localparam longint unsigned SAMPLE_RATE = 44100;
  localparam int unsigned STEP_SHIFT = 17;
  localparam int unsigned INDEX_SHIFT = 17;
  localparam longint unsigned NUM = HALF_CLOCK << STEP_SHIFT;
  localparam int unsigned NUM_W = $clog2(NUM + 1);
  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam int unsigned SR_W = $clog2(SAMPLE_RATE + 1);
  localparam int unsigned DEN_W = 13 + SR_W;
  localparam int unsigned MIX_W = 11;

  localparam logic [2:0] OP_WAVE0 = 3'd0;
  localparam logic [2:0] OP_PERIOD = 3'd1;
  localparam logic [2:0] OP_VOLUME = 3'd2;
  localparam logic [2:0] OP_KEYON = 3'd3;
  localparam logic [2:0] OP_WAVE1 = 3'd4;
  localparam logic [2:0] OP_TEST = 3'd5;

  localparam logic [7:0] IDX_SHARED = 8'h60;
  localparam logic [7:0] TEST_NOWAVE = 8'h40;
  localparam logic [7:0] TEST_PHASE = 8'h20;
  localparam logic [11:0] MIN_PERIOD = 12'd9;
endpackage
`default_nettype wire

[sv/wavetable_sound_generator_5ch.sv]
// bus write: taken in S_IDLE; a shared-channel wave write adds S_WR2; a period write
// may go on through S_MUL and S_DIV, the one-bit-per-cycle step divider
// sample tick: each channel goes through S_RD and S_ACC via the wave ram read port,
// then S_DONE; one item in flight at a time; result held in an output register
// rst clears all channel state, index/test registers and wave valid bits at once
`default_nettype none
module wavetable_sound_generator_5ch (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // port [7:0], write_data [15:8]
  input  wire logic        s_tuser,   // operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata    // mixed_sample [10:0], zero [15:11]
);
  import wsg_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WR2  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state;
  logic [31:0] phase [NCH];
  logic [31:0] step [NCH];
  logic [11:0] period [NCH];
  logic [3:0] volume [NCH];
  logic [NCH-1:0] keyon;
  logic [7:0] index;
  logic [7:0] test;
  logic [WAVE_DEPTH-1:0] wvalid;
  logic vld_q;
  logic [7:0] wbyte;

  logic [2:0] ch;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] dcnt;
  logic signed [MIX_W-1:0] acc;

  logic we;
  logic [WAVE_AW-1:0] waddr;
  logic [7:0] wdata;
  logic [WAVE_AW-1:0] raddr;
  logic [7:0] rdata;

  logic accept;
  logic [7:0] port;
  logic [7:0] data;
  logic [2:0] pch;
  logic [11:0] per_next;
  logic [31:0] ph_adv;
  logic [4:0] pos;
  logic [DEN_W:0] rsh;
  logic rfit;
  logic signed [7:0] wave_s;
  logic signed [12:0] prod;
  logic signed [8:0] contrib;

  assign port = s_tdata[7:0];
  assign data = s_tdata[15:8];
  assign s_tready = (state == S_IDLE);
  assign accept = s_tvalid && s_tready;
  assign pch = index[3:1];

  always_comb begin
    per_next = period[pch];
    if (index[0]) begin
      per_next = {data[3:0], period[pch][7:0]};
    end else begin
      per_next = {period[pch][11:8], data};
    end
  end

  assign ph_adv = (step[ch] != 32'd0) ? phase[ch] + step[ch] : phase[ch];
  assign pos = ph_adv[INDEX_SHIFT +: 5];
  assign raddr = WAVE_AW'({ch, pos});

  assign wave_s = vld_q ? $signed(rdata) : 8'sd0;
  assign prod = wave_s * $signed({1'b0, volume[ch]});
  assign contrib = 9'(prod >>> 4);

  assign rsh = {rem, NUM[dcnt]};
  assign rfit = rsh >= {1'b0, den};

  // wave writes: index below the shared range maps straight onto the ram
  always_comb begin
    we = 1'b0;
    waddr = WAVE_AW'(index);
    wdata = data;
    if (state == S_WR2) begin
      we = 1'b1;
      waddr = WAVE_AW'({3'd4, index[4:0]});
      wdata = wbyte;
    end else if (accept && !s_tuser && port[0] && !test[6]
                 && (port[3:1] == OP_WAVE0 || port[3:1] == OP_WAVE1)
                 && port[7:4] == 4'd0) begin
      we = 1'b1;
      if (index >= IDX_SHARED) begin
        waddr = WAVE_AW'({3'd3, index[4:0]});
      end
    end
  end

  wsg_ram #(.WIDTH(8), .DEPTH(WAVE_DEPTH)) u_wave (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    vld_q <= wvalid[raddr];
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NCH; i++) begin
        phase[i] <= '0;
        step[i] <= '0;
        period[i] <= '0;
        volume[i] <= '0;
      end
      keyon <= '0;
      index <= '0;
      test <= '0;
      wvalid <= '0;
      m_tvalid <= 1'b0;
      ch <= '0;
    end else begin
      if (we) begin
        wvalid[waddr] <= 1'b1;
      end
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            wbyte <= data;
            if (s_tuser) begin
              ch <= '0;
              acc <= '0;
              state <= S_RD;
            end else if (!port[0]) begin
              index <= data;
            end else if (port[7:4] == 4'd0) begin
              case (port[3:1])
                OP_WAVE0, OP_WAVE1: begin
                  if (!test[6] && index >= IDX_SHARED) begin
                    state <= S_WR2;
                  end
                end
                OP_PERIOD: begin
                  if (index[7:4] == 4'd0 && 32'(pch) < NCH) begin
                    period[pch] <= per_next;
                    ch <= pch;
                    if (test[5]) begin
                      phase[pch] <= '1;
                    end else if (per_next < MIN_PERIOD) begin
                      phase[pch] <= {phase[pch][31:16], 16'hFFFF};
                      step[pch] <= '0;
                    end else begin
                      phase[pch] <= {phase[pch][31:16], 16'h0000};
                      state <= S_MUL;
                    end
                  end
                end
                OP_VOLUME: begin
                  if (32'(index[2:0]) < NCH) begin
                    volume[index[2:0]] <= data[3:0];
                  end
                end
                OP_KEYON: keyon <= data[NCH-1:0];
                OP_TEST: test <= data;
                default: ;
              endcase
            end
          end
        end
        S_WR2: state <= S_IDLE;
        S_MUL: begin
          den <= (DEN_W'(period[ch]) + DEN_W'(1)) * DEN_W'(SAMPLE_RATE);
          rem <= '0;
          quo <= '0;
          dcnt <= CNT_W'(NUM_W - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= rfit ? DEN_W'(rsh - {1'b0, den}) : rsh[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], rfit};
          dcnt <= dcnt - 1'b1;
          if (dcnt == '0) begin
            step[ch] <= 32'({quo[NUM_W-2:0], rfit});
            state <= S_IDLE;
          end
        end
        S_RD: begin
          phase[ch] <= ph_adv;
          state <= S_ACC;
        end
        S_ACC: begin
          // stopped channels give nothing even when keyed
          if (keyon[ch] && step[ch] != 32'd0) begin
            acc <= acc + MIX_W'(contrib);
          end
          if (32'(ch) == NCH - 1) begin
            state <= S_DONE;
          end else begin
            ch <= ch + 1'b1;
            state <= S_RD;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {5'd0, acc};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[sv/wsg_ram.sv]
`default_nettype none
module wsg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 160
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
